### rtl/response_frame_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the response frame parser
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_PARSER_CORE_ASSERT_SVH
`define RESPONSE_FRAME_PARSER_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define RFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and codes of the response frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_START_MARKER = 3'd0;
    localparam logic [2:0] CFG_END_MARKER   = 3'd1;
    localparam logic [2:0] CFG_ERROR_MARKER = 3'd2;
    localparam logic [2:0] CFG_REPLY_MASK   = 3'd3;
    localparam logic [2:0] CFG_WAIT_LIMIT   = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_START_MARKER = 8'hE0;
    localparam logic [7:0]  RST_END_MARKER   = 8'hEE;
    localparam logic [7:0]  RST_ERROR_MARKER = 8'hEF;
    localparam logic [7:0]  RST_REPLY_MASK   = 8'h80;
    localparam logic [11:0] RST_WAIT_LIMIT   = 12'd1000;

    // input word kinds
    localparam logic KIND_ARM  = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    // result word kinds
    localparam logic OUT_DATA   = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    // frame formats
    localparam logic [1:0] FMT_COUNTED = 2'd0;
    localparam logic [1:0] FMT_LEN8    = 2'd1;
    localparam logic [1:0] FMT_LEN16   = 2'd2;
    localparam logic [1:0] FMT_LIST    = 2'd3;

    // final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ERROR     = 3'd1;
    localparam logic [2:0] ST_TIMEOUT   = 3'd2;
    localparam logic [2:0] ST_BAD_REPLY = 3'd3;
    localparam logic [2:0] ST_COUNT     = 3'd4;
    localparam logic [2:0] ST_NO_PARAMS = 3'd5;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [7:0]  error_marker;
        logic [7:0]  reply_mask;
        logic [11:0] wait_limit;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [7:0] expected_cmd;
        logic [7:0] expected_params;
        logic [1:0] frame_format;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic        out_kind;
        logic [7:0]  data_byte;
        logic [7:0]  param_index;
        logic [15:0] byte_index;
        logic [2:0]  status;
        logic [15:0] total_length;
        logic        end_matched;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

### rtl/rfp_parser.sv
// ----------------------------------------------------------------------------
// rfp_parser
// Frame state and single-word step logic: takes one word, updates the parse
// state and forms at most one result word in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "response_frame_parser_core_assert.svh"

module rfp_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire rfp_pkg::t_item   i_item,
    input  wire rfp_pkg::t_cfg    i_cfg,
    output rfp_pkg::t_result      o_res
);
    import rfp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAIT, PH_CMD, PH_COUNT, PH_LEN8,
        PH_LENHI, PH_LENLO, PH_DATA, PH_END
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [11:0] r_wait_count,  n_wait_count;
    logic [7:0]  r_want_cmd,    n_want_cmd;
    logic [7:0]  r_want_count,  n_want_count;
    logic [1:0]  r_format,      n_format;
    logic [7:0]  r_param_total, n_param_total;
    logic [7:0]  r_param_now,   n_param_now;
    logic [15:0] r_length_now,  n_length_now;
    logic [15:0] r_byte_now,    n_byte_now;

    logic [7:0]  w_b;
    logic [7:0]  w_param_inc;
    logic [15:0] w_byte_inc;
    logic [15:0] w_len_lo;
    t_phase      w_after_param;

    assign w_b         = i_item.rx_byte;
    assign w_param_inc = r_param_now + 8'd1;
    assign w_byte_inc  = r_byte_now + 16'd1;
    assign w_len_lo    = {r_length_now[15:8], w_b};

    // phase that follows a finished parameter or block
    always_comb begin
        if (r_format == FMT_LIST) begin
            w_after_param = (w_param_inc == r_param_total) ? PH_END : PH_LEN8;
        end else begin
            w_after_param = PH_END;
        end
    end

    // one parse step
    always_comb begin
        n_phase       = r_phase;
        n_wait_count  = r_wait_count;
        n_want_cmd    = r_want_cmd;
        n_want_count  = r_want_count;
        n_format      = r_format;
        n_param_total = r_param_total;
        n_param_now   = r_param_now;
        n_length_now  = r_length_now;
        n_byte_now    = r_byte_now;
        o_res         = '0;

        if (i_item.kind == KIND_ARM) begin
            // load a new frame wait, dropping any frame in progress
            n_want_cmd    = i_item.expected_cmd;
            n_want_count  = i_item.expected_params;
            n_format      = i_item.frame_format;
            n_wait_count  = '0;
            n_param_total = '0;
            n_param_now   = '0;
            n_length_now  = '0;
            n_byte_now    = '0;
            n_phase       = PH_WAIT;
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    if (w_b == i_cfg.error_marker) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_ERROR;
                    end else if (w_b == i_cfg.start_marker) begin
                        n_phase = PH_CMD;
                    end else if (r_wait_count >= i_cfg.wait_limit) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_TIMEOUT;
                    end else begin
                        n_wait_count = r_wait_count + 12'd1;
                    end
                end
                PH_CMD: begin
                    if (w_b != (r_want_cmd | i_cfg.reply_mask)) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_BAD_REPLY;
                    end else begin
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_param_total = w_b;
                    n_param_now   = '0;
                    n_length_now  = '0;
                    case (r_format)
                        FMT_COUNTED: begin
                            if (w_b != r_want_count) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_COUNT;
                            end else begin
                                n_phase = PH_LEN8;
                            end
                        end
                        FMT_LIST: begin
                            if (w_b == 8'd0) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_NO_PARAMS;
                            end else if (w_b != r_want_count) begin
                                o_res.valid  = 1'b1;
                                o_res.status = ST_COUNT;
                            end else begin
                                n_phase = PH_LEN8;
                            end
                        end
                        default: begin
                            // block formats: an empty block goes straight to close
                            if (w_b == 8'd0) begin
                                n_phase = PH_END;
                            end else if (r_format == FMT_LEN8) begin
                                n_phase = PH_LEN8;
                            end else begin
                                n_phase = PH_LENHI;
                            end
                        end
                    endcase
                end
                PH_LEN8: begin
                    n_length_now = {8'd0, w_b};
                    n_byte_now   = '0;
                    n_phase      = (w_b == 8'd0) ? w_after_param : PH_DATA;
                    if (w_b == 8'd0) begin
                        n_param_now = (r_format == FMT_LIST) ? w_param_inc : r_param_now;
                    end
                end
                PH_LENHI: begin
                    n_length_now = {w_b, 8'd0};
                    n_phase      = PH_LENLO;
                end
                PH_LENLO: begin
                    n_length_now = w_len_lo;
                    n_byte_now   = '0;
                    n_phase      = (w_len_lo == 16'd0) ? w_after_param : PH_DATA;
                    if (w_len_lo == 16'd0) begin
                        n_param_now = (r_format == FMT_LIST) ? w_param_inc : r_param_now;
                    end
                end
                PH_DATA: begin
                    o_res.valid       = 1'b1;
                    o_res.out_kind    = OUT_DATA;
                    o_res.data_byte   = w_b;
                    o_res.param_index = r_param_now;
                    o_res.byte_index  = r_byte_now;
                    n_byte_now        = w_byte_inc;
                    if (w_byte_inc >= r_length_now) begin
                        n_phase     = w_after_param;
                        n_param_now = (r_format == FMT_LIST) ? w_param_inc : r_param_now;
                    end
                end
                PH_END: begin
                    o_res.valid        = 1'b1;
                    o_res.status       = ST_OK;
                    o_res.total_length = (r_format == FMT_LIST) ? 16'd0 : r_length_now;
                    o_res.end_matched  = (w_b == i_cfg.end_marker);
                end
                default: begin
                    // idle: drop the byte
                end
            endcase

            // every status word closes the frame
            if (o_res.valid && r_phase != PH_DATA) begin
                o_res.out_kind = OUT_STATUS;
                o_res.last     = 1'b1;
                n_phase        = PH_IDLE;
            end
        end
    end

    // hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_wait_count  <= '0;
            r_want_cmd    <= '0;
            r_want_count  <= '0;
            r_format      <= '0;
            r_param_total <= '0;
            r_param_now   <= '0;
            r_length_now  <= '0;
            r_byte_now    <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_wait_count  <= n_wait_count;
            r_want_cmd    <= n_want_cmd;
            r_want_count  <= n_want_count;
            r_format      <= n_format;
            r_param_total <= n_param_total;
            r_param_now   <= n_param_now;
            r_length_now  <= n_length_now;
            r_byte_now    <= n_byte_now;
        end
    end

    `RFP_ASSERT_NXT(a_idle_after_status, i_fire && o_res.valid && o_res.last, r_phase == PH_IDLE, "parser not idle after a status word")
    `RFP_ASSERT_NOW(a_arm_silent, i_fire && i_item.kind == KIND_ARM, !o_res.valid, "arm word produced a result")
    `RFP_ASSERT_NOW(a_data_in_range, r_phase == PH_DATA, r_byte_now < r_length_now, "byte index past block length")

endmodule

`default_nettype wire

### rtl/response_frame_parser_core.sv
// ----------------------------------------------------------------------------
// response_frame_parser_core
// Start/end delimited reply frame parser with four frame formats.
// ----------------------------------------------------------------------------
// One word is taken per clock, sustained, while the master side keeps up; either
// side may stall freely. A word accepted at one edge is held in an input
// register and stepped through the parser at the next edge at which the result
// register is free. Its result (if any) is visible on the master side from then
// on; with the master side ready, the step is never held back. The only loop is
// the parse state update, which is computed combinationally and registered on
// each step. While a result waits unread the step stalls, one further word is
// taken into the input register, and then the slave side backs up.
// Configuration writes go on the plain write port and should be made while no
// word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "response_frame_parser_core_assert.svh"

module response_frame_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] rx_byte, [15:8] expected_cmd, [23:16] expected_params,
    // [25:24] frame_format, [31:26] zero
    input  wire logic [31:0] s_axis_tdata,
    // [0] kind
    input  wire logic        s_axis_tuser,
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] data_byte, [15:8] param_index, [31:16] byte_index, [34:32] status,
    // [50:35] total_length, [51] end_matched, [55:52] zero
    output logic [55:0]      m_axis_tdata,
    // [0] out_kind
    output logic             m_axis_tuser,
    // last
    output logic             m_axis_tlast
);
    import rfp_pkg::*;

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    t_result w_res;
    logic    w_out_free;
    logic    w_step;
    logic    w_take;

    // step the held word when the result register can take its result
    assign w_out_free    = !r_out.valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= RST_START_MARKER;
            r_cfg.end_marker   <= RST_END_MARKER;
            r_cfg.error_marker <= RST_ERROR_MARKER;
            r_cfg.reply_mask   <= RST_REPLY_MASK;
            r_cfg.wait_limit   <= RST_WAIT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg_data[7:0];
                CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_data[7:0];
                CFG_ERROR_MARKER: r_cfg.error_marker <= i_cfg_data[7:0];
                CFG_REPLY_MASK:   r_cfg.reply_mask   <= i_cfg_data[7:0];
                CFG_WAIT_LIMIT:   r_cfg.wait_limit   <= i_cfg_data;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.kind            <= s_axis_tuser;
            r_in.rx_byte         <= s_axis_tdata[7:0];
            r_in.expected_cmd    <= s_axis_tdata[15:8];
            r_in.expected_params <= s_axis_tdata[23:16];
            r_in.frame_format    <= s_axis_tdata[25:24];
        end
    end

    rfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register: load on a step, clear when taken with nothing new
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_step) begin
            r_out.valid <= w_res.valid;
        end else if (m_axis_tready) begin
            r_out.valid <= 1'b0;
        end
        if (w_step && w_res.valid) begin
            r_out.out_kind     <= w_res.out_kind;
            r_out.data_byte    <= w_res.data_byte;
            r_out.param_index  <= w_res.param_index;
            r_out.byte_index   <= w_res.byte_index;
            r_out.status       <= w_res.status;
            r_out.total_length <= w_res.total_length;
            r_out.end_matched  <= w_res.end_matched;
            r_out.last         <= w_res.last;
        end
    end

    assign m_axis_tvalid = r_out.valid;
    assign m_axis_tuser  = r_out.out_kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'd0, r_out.end_matched, r_out.total_length, r_out.status,
                            r_out.byte_index, r_out.param_index, r_out.data_byte};

    `RFP_ASSERT_NOW(a_last_on_status, m_axis_tvalid, m_axis_tuser == m_axis_tlast, "tlast does not mark the status word")
    `RFP_ASSERT_NOW(a_data_no_status, m_axis_tvalid && m_axis_tuser == OUT_DATA, m_axis_tdata[34:32] == ST_OK, "data word carries a status")
    `RFP_ASSERT_NOW(a_fail_no_length, m_axis_tvalid && m_axis_tdata[34:32] != ST_OK, m_axis_tdata[51:35] == 17'd0, "failed status carries length or end match")

endmodule

`default_nettype wire
